// ===== hw/rtl/rsbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsbs_pkg
// Shared types and constants of the random subset bitmap sampler.
// ----------------------------------------------------------------------------
package rsbs_pkg;

	localparam int DEF_MAX_SAMPLES = 4096;
	localparam int DEF_WORD_BITS   = 64;

	localparam int TOT_W      = 13;
	localparam int RQ_W       = 32;
	localparam int MAG_W      = 64;
	localparam int PRE_W      = 5;
	localparam int POST_W     = 6;
	localparam int FUNC_W     = 2;
	localparam int RND_W      = 32;
	localparam int WIDX_W     = 7;
	localparam int CHOSEN_W   = 12;
	localparam int RDATA_W    = 64;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 64;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 80;
	localparam int QDEPTH     = 2;

	localparam logic [FUNC_W-1:0] FUNC_START  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_RANDOM = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_COUNT      = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SELECTED_COUNT   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_QUOTIENT   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAGIC_MULTIPLIER = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PRE_SHIFT        = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_POST_SHIFT       = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ROUND_INCREMENT  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TWO_BIT_PACKING  = 4'd7;

	typedef enum logic [1:0] {
		KIND_START,
		KIND_RANDOM,
		KIND_READ,
		KIND_NOP
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [RND_W-1:0]  rnd;
		logic [RND_W-1:0]  scaled;
		logic [WIDX_W-1:0] widx;
	} item_t;

	typedef struct packed {
		logic [TOT_W-1:0]  total;
		logic [TOT_W-1:0]  selected;
		logic [RQ_W-1:0]   rq;
		logic [MAG_W-1:0]  magic;
		logic [PRE_W-1:0]  pre;
		logic [POST_W-1:0] post;
		logic              rinc;
		logic              pack;
	} cfg_t;

	typedef struct packed {
		logic                accepted;
		logic [CHOSEN_W-1:0] chosen;
		logic                done;
		logic [RDATA_W-1:0]  rdata;
	} res_t;

endpackage

// ===== hw/rtl/rsbs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsbs_front
// Input side: takes beats, decodes the function and pre-scales random words.
// ----------------------------------------------------------------------------
module rsbs_front
	import rsbs_pkg::*;
(
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [FUNC_W-1:0] func,
	input  logic [RND_W-1:0]  random_word,
	input  logic [WIDX_W-1:0] word_index,
	input  logic [PRE_W-1:0]  pre_shift,
	input  logic              round_increment,
	input  logic              q_full,
	output logic              push,
	output item_t             item
);

	kind_t kind;

	always_comb begin
		unique case (func)
			FUNC_START:  kind = KIND_START;
			FUNC_RANDOM: kind = KIND_RANDOM;
			FUNC_READ:   kind = KIND_READ;
			default:     kind = KIND_NOP;
		endcase
	end

	assign in_ready    = !q_full;
	assign push        = in_valid && !q_full;
	assign item.kind   = kind;
	assign item.rnd    = random_word;
	assign item.scaled = (random_word >> pre_shift) + RND_W'(round_increment);
	assign item.widx   = word_index;

endmodule

// ===== hw/rtl/rsbs_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsbs_queue
// Short queue of decoded items between the front and the back.
// ----------------------------------------------------------------------------
module rsbs_queue
	import rsbs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t item_in,
	output logic  full,
	input  logic  pop,
	output logic  valid,
	output item_t item_out
);

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	item_t             entries_q [QDEPTH];
	logic [PTR_W-1:0]  wptr_q;
	logic [PTR_W-1:0]  rptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = count_q == CNT_W'(QDEPTH);
	assign valid    = count_q != '0;
	assign item_out = entries_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + PTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wptr_q] <= item_in;
		end
	end

endmodule

// ===== hw/rtl/rsbs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsbs_back
// Back side: sequencer with index math, bitmap memory and result register.
// ----------------------------------------------------------------------------
module rsbs_back
	import rsbs_pkg::*;
#(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
	parameter int WORD_BITS   = DEF_WORD_BITS
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  q_valid,
	input  item_t q_item,
	output logic  q_pop,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  out_res
);

	localparam int WORDS  = (2 * MAX_SAMPLES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW     = $clog2(WORDS);
	localparam int LB     = $clog2(WORD_BITS);
	localparam int HALF   = WORD_BITS / 2;
	localparam int CW     = ((AW + LB > TOT_W) ? AW + LB : TOT_W) + 1;
	localparam int SW     = $clog2(MAX_SAMPLES + 1);
	localparam int EW     = (TOT_W > SW) ? TOT_W : SW;
	localparam int DIV_SH = TOT_W + 7;
	localparam int MW     = DIV_SH - 3;
	localparam int M_HALF = (1 << DIV_SH) / HALF;
	localparam int M_FULL = (1 << DIV_SH) / WORD_BITS;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MISC,
		ST_RDOUT,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_INDEX,
		ST_DIV,
		ST_LOCATE,
		ST_UPDATE
	} state_t;

	state_t               state_q;
	kind_t                kind_q;
	logic [RND_W-1:0]     rnd_q;
	logic [RND_W-1:0]     scaled_q;
	logic                 read_ok_q;
	logic [RND_W-1:0]     bound_q;
	logic [63:0]          p_lo_q;
	logic [31:0]          p_hi_q;
	logic [TOT_W-1:0]     idx_q;
	logic                 hit_q;
	logic [CHOSEN_W-1:0]  chosen_q;
	logic [TOT_W-1:0]     qest_q;
	logic [LB-1:0]        bit_q;
	logic [TOT_W-1:0]     marks_q;
	logic                 clear_mode_q;
	logic [TOT_W-1:0]     snap_tot_q;
	logic                 snap_pack_q;
	logic [WORDS-1:0]     word_valid_q;
	logic                 out_valid_q;
	res_t                 out_res_q;

	logic [WORD_BITS-1:0] mem [WORDS];
	logic [WORD_BITS-1:0] rd_data_q;
	logic [AW-1:0]        rd_addr_q;
	logic                 rd_vld_q;

	function automatic logic [WORD_BITS-1:0] fill_word(input logic [AW-1:0] addr,
			input logic [TOT_W-1:0] tot, input logic pack);
		logic [CW-1:0]        base;
		logic [CW-1:0]        totx;
		logic [CW-1:0]        n;
		logic [WORD_BITS-1:0] w;
		base = pack ? CW'(addr) * CW'(HALF) : CW'(addr) * CW'(WORD_BITS);
		totx = CW'(tot);
		n    = (totx > base) ? totx - base : '0;
		for (int k = 0; k < WORD_BITS; k++) begin
			w[k] = pack ? (((k & 1) == 0) && (CW'(k >> 1) < n)) : (CW'(k) < n);
		end
		return w;
	endfunction

	// effective total and start setup
	logic [EW-1:0]    tot_ext;
	logic [EW-1:0]    eff_w;
	logic [TOT_W-1:0] eff_tot;
	logic [TOT_W-1:0] sel;
	logic             set_mode;
	logic [TOT_W-1:0] start_marks;

	assign tot_ext     = EW'(cfg.total);
	assign eff_w       = (tot_ext > EW'(MAX_SAMPLES)) ? EW'(MAX_SAMPLES) : tot_ext;
	assign eff_tot     = eff_w[TOT_W-1:0];
	assign sel         = (cfg.selected > eff_tot) ? eff_tot : cfg.selected;
	assign set_mode    = {sel, 1'b0} < {1'b0, eff_tot};
	assign start_marks = set_mode ? sel : eff_tot - sel;

	// multiplies
	logic [TOT_W+RQ_W-1:0] bound_full;
	logic [63:0]           p_lo_full;
	logic [63:0]           p_hi_full;

	assign bound_full = (TOT_W+RQ_W)'(cfg.total) * (TOT_W+RQ_W)'(cfg.rq);
	assign p_lo_full  = 64'(cfg.magic[31:0]) * 64'(scaled_q);
	assign p_hi_full  = 64'(cfg.magic[63:32]) * 64'(scaled_q);

	// index from product
	logic [31:0]      sum_hi;
	logic [63:0]      prod;
	logic [63:0]      prod_sh;
	logic [31:0]      idx32;
	logic [RND_W-1:0] bound_m1;
	logic             in_bound;
	logic             idx_hit;

	assign sum_hi   = p_hi_q + p_lo_q[63:32];
	assign prod     = {sum_hi, p_lo_q[31:0]};
	assign prod_sh  = prod >> cfg.post;
	assign idx32    = prod_sh[31:0];
	assign bound_m1 = bound_q - RND_W'(1);
	assign in_bound = rnd_q <= bound_m1;
	assign idx_hit  = in_bound && (marks_q != '0) && (idx32 < 32'(eff_tot));

	// word and bit by reciprocal multiply with one correction
	logic [MW-1:0]        mulsel;
	logic [TOT_W+MW-1:0]  qprod;
	logic [TOT_W+MW-1:0]  qsh;
	logic [TOT_W-1:0]     dv;
	logic [2*TOT_W-1:0]   qd;
	logic [TOT_W-1:0]     rem0;
	logic                 corr;
	logic [TOT_W-1:0]     rem;
	logic [TOT_W-1:0]     q_fix;
	logic [AW+TOT_W-1:0]  q_ext;
	logic [TOT_W-1:0]     bpos;

	assign mulsel = cfg.pack ? MW'(M_HALF) : MW'(M_FULL);
	assign qprod  = (TOT_W+MW)'(idx_q) * (TOT_W+MW)'(mulsel);
	assign qsh    = qprod >> DIV_SH;
	assign dv     = cfg.pack ? TOT_W'(HALF) : TOT_W'(WORD_BITS);
	assign qd     = (2*TOT_W)'(qest_q) * (2*TOT_W)'(dv);
	assign rem0   = idx_q - qd[TOT_W-1:0];
	assign corr   = rem0 >= dv;
	assign rem    = corr ? rem0 - dv : rem0;
	assign q_fix  = qest_q + TOT_W'(corr);
	assign q_ext  = (AW+TOT_W)'(q_fix);
	assign bpos   = cfg.pack ? {rem[TOT_W-2:0], 1'b0} : rem;

	// read port
	logic [AW+WIDX_W-1:0] widx_ext;
	logic                 widx_ok;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;

	assign widx_ext = (AW+WIDX_W)'(q_item.widx);
	assign widx_ok  = widx_ext < (AW+WIDX_W)'(WORDS);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		if (state_q == ST_IDLE && q_valid && q_item.kind == KIND_READ) begin
			rd_en   = 1'b1;
			rd_addr = widx_ok ? widx_ext[AW-1:0] : '0;
		end else if (state_q == ST_LOCATE) begin
			rd_en   = 1'b1;
			rd_addr = hit_q ? q_ext[AW-1:0] : '0;
		end
	end

	// update
	logic [WORD_BITS-1:0] cur;
	logic                 isset;
	logic                 flip;
	logic                 out_free;
	logic                 wr_en;
	logic [WORD_BITS-1:0] wr_data;
	logic [TOT_W-1:0]     marks_dec;

	assign cur       = rd_vld_q ? rd_data_q :
	                   (clear_mode_q ? fill_word(rd_addr_q, snap_tot_q, snap_pack_q) : '0);
	assign isset     = cur[bit_q];
	assign flip      = hit_q && (clear_mode_q ? isset : !isset);
	assign out_free  = !out_valid_q || out_ready;
	assign wr_en     = state_q == ST_UPDATE && out_free && flip;
	assign wr_data   = cur ^ (WORD_BITS'(1) << bit_q);
	assign marks_dec = marks_q - TOT_W'(flip);

	assign q_pop     = state_q == ST_IDLE && q_valid;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			word_valid_q <= '0;
			marks_q      <= '0;
			clear_mode_q <= 1'b0;
			snap_tot_q   <= '0;
			snap_pack_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						kind_q    <= q_item.kind;
						rnd_q     <= q_item.rnd;
						scaled_q  <= q_item.scaled;
						read_ok_q <= widx_ok;
						unique case (q_item.kind)
							KIND_RANDOM: state_q <= ST_MUL_LO;
							KIND_READ:   state_q <= ST_RDOUT;
							default:     state_q <= ST_MISC;
						endcase
					end
				end
				ST_MISC: begin
					if (out_free) begin
						out_valid_q        <= 1'b1;
						out_res_q.accepted <= 1'b0;
						out_res_q.chosen   <= '0;
						out_res_q.rdata    <= '0;
						if (kind_q == KIND_START) begin
							out_res_q.done <= start_marks == '0;
							marks_q        <= start_marks;
							clear_mode_q   <= !set_mode;
							snap_tot_q     <= eff_tot;
							snap_pack_q    <= cfg.pack;
							word_valid_q   <= '0;
						end else begin
							out_res_q.done <= marks_q == '0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_RDOUT: begin
					if (out_free) begin
						out_valid_q        <= 1'b1;
						out_res_q.accepted <= 1'b0;
						out_res_q.chosen   <= '0;
						out_res_q.done     <= marks_q == '0;
						out_res_q.rdata    <= read_ok_q ? RDATA_W'(cur) : '0;
						state_q            <= ST_IDLE;
					end
				end
				ST_MUL_LO: begin
					p_lo_q  <= p_lo_full;
					bound_q <= bound_full[RND_W-1:0];
					state_q <= ST_MUL_HI;
				end
				ST_MUL_HI: begin
					p_hi_q  <= p_hi_full[31:0];
					state_q <= ST_INDEX;
				end
				ST_INDEX: begin
					idx_q    <= idx32[TOT_W-1:0];
					hit_q    <= idx_hit;
					chosen_q <= in_bound ? idx32[CHOSEN_W-1:0] : '0;
					state_q  <= ST_DIV;
				end
				ST_DIV: begin
					qest_q  <= qsh[TOT_W-1:0];
					state_q <= ST_LOCATE;
				end
				ST_LOCATE: begin
					bit_q   <= bpos[LB-1:0];
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (out_free) begin
						out_valid_q        <= 1'b1;
						out_res_q.accepted <= flip;
						out_res_q.chosen   <= chosen_q;
						out_res_q.done     <= marks_dec == '0;
						out_res_q.rdata    <= '0;
						marks_q            <= marks_dec;
						if (flip) begin
							word_valid_q[rd_addr_q] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[rd_addr_q] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
			rd_addr_q <= rd_addr;
			rd_vld_q  <= word_valid_q[rd_addr];
		end
	end

`ifndef SYNTHESIS
	a_start_clears_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MISC && out_free && kind_q == KIND_START) |=> (word_valid_q == '0))
		else $error("start did not clear bitmap valid bits");

	a_flip_counts_down: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && out_free && flip) |=> (marks_q == $past(marks_q) - TOT_W'(1)))
		else $error("accepted word did not decrement marks");

	a_no_flip_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && flip) |-> (marks_q != '0))
		else $error("bit flipped with no marks remaining");

	a_oob_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RDOUT && out_free && !read_ok_q) |=> (out_res_q.rdata == '0))
		else $error("out of range read returned data");
`endif

endmodule

// ===== hw/rtl/random_subset_bitmap_sampler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_subset_bitmap_sampler_core
// Marks a random subset of samples in a bitmap from offered random words.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel writes one register per beat (index, data); always ready.
//   The user must write registers only while no item is in flight; the core does not enforce it.
//   s_axis carries one item per beat, tuser holds the function code
//   (start, random word, read word). m_axis returns one result per item.
//   Start and read items go straight to a result state; the back sequencer
//   runs one item at a time and takes a random word through the
//   split 64-bit magic multiply, the word/bit locate and one bitmap
//   read-modify-write. The front takes new beats into a two-entry queue
//   while the back works, so input and output stall independently.
//   A stalled m_axis holds the result; the back waits and the queue fills.
//   Reset clears the bitmap (per-word valid bits), the mark count and the
//   queue at once; no clearing pass is needed. A start item also just
//   drops the valid bits, so it finishes in constant time.
// ----------------------------------------------------------------------------
module random_subset_bitmap_sampler_core
	import rsbs_pkg::*;
#(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
	parameter int WORD_BITS   = DEF_WORD_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// random_word[31:0], word_index[38:32], zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// func[1:0]
	input  logic [FUNC_W-1:0]     s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// accepted[0], chosen_index[12:1], done_res[13], read_data[77:14], zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t  cfg_q;
	logic  q_full;
	logic  q_push;
	logic  q_pop;
	logic  q_valid;
	item_t q_item_in;
	item_t q_item_out;
	res_t  res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.total    <= TOT_W'(2);
			cfg_q.selected <= '0;
			cfg_q.rq       <= 32'h8000_0000;
			cfg_q.magic    <= '0;
			cfg_q.pre      <= '0;
			cfg_q.post     <= '0;
			cfg_q.rinc     <= 1'b0;
			cfg_q.pack     <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TOTAL_COUNT:      cfg_q.total    <= cfg_data[TOT_W-1:0];
				REG_SELECTED_COUNT:   cfg_q.selected <= cfg_data[TOT_W-1:0];
				REG_RANGE_QUOTIENT:   cfg_q.rq       <= cfg_data[RQ_W-1:0];
				REG_MAGIC_MULTIPLIER: cfg_q.magic    <= cfg_data[MAG_W-1:0];
				REG_PRE_SHIFT:        cfg_q.pre      <= cfg_data[PRE_W-1:0];
				REG_POST_SHIFT:       cfg_q.post     <= cfg_data[POST_W-1:0];
				REG_ROUND_INCREMENT:  cfg_q.rinc     <= cfg_data[0];
				REG_TWO_BIT_PACKING:  cfg_q.pack     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	rsbs_front u_front (
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.func            (s_axis_tuser),
		.random_word     (s_axis_tdata[RND_W-1:0]),
		.word_index      (s_axis_tdata[RND_W+WIDX_W-1:RND_W]),
		.pre_shift       (cfg_q.pre),
		.round_increment (cfg_q.rinc),
		.q_full          (q_full),
		.push            (q_push),
		.item            (q_item_in)
	);

	rsbs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.item_in  (q_item_in),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.item_out (q_item_out)
	);

	rsbs_back #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.WORD_BITS   (WORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item_out),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {2'b00, res.rdata, res.done, res.chosen, res.accepted};

endmodule
